### src/rac_pkg.sv
// ============================================================================
// rac_pkg
// Shared types, codes and helpers for the rational accumulator ALU.
// ============================================================================
`default_nettype none

package rac_pkg;

  // Default signed width of the held fraction.
  localparam int RAC_WIDTH = 32;

  // Operand field width and sign-magnitude working width.
  localparam int OP_W  = 32;
  localparam int DIV_W = 64;
  localparam int CNT_W = $clog2(DIV_W);

  // Operation codes.
  localparam logic [2:0] FN_LOAD = 3'd0;
  localparam logic [2:0] FN_ADD  = 3'd1;
  localparam logic [2:0] FN_SUB  = 3'd2;
  localparam logic [2:0] FN_MUL  = 3'd3;
  localparam logic [2:0] FN_DIV  = 3'd4;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_DEN = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic            neg;
    logic [OP_W-1:0] mag;
  } sm32_t;

  typedef struct packed {
    logic             neg;
    logic [DIV_W-1:0] mag;
  } sm64_t;

  // Request and response of the shared divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

  // Split a two's complement word into sign and magnitude.
  function automatic sm32_t to_sm32(input logic [OP_W-1:0] v);
    sm32_t r;
    r.neg = v[OP_W-1];
    r.mag = v[OP_W-1] ? (~v + OP_W'(1)) : v;
    return r;
  endfunction

endpackage

`default_nettype wire

### src/rac_div.sv
// ============================================================================
// rac_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module rac_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rac_pkg::div_req_t req,
  output rac_pkg::div_rsp_t      rsp
);
  import rac_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] dsr_r, dsr_nxt;

  logic [DIV_W:0]   sh;
  logic [DIV_W+1:0] diff;
  logic             ge;

  always_comb begin
    sh       = {rem_r, quo_r[DIV_W-1]};
    diff     = {1'b0, sh} - {2'b00, dsr_r};
    ge       = ~diff[DIV_W+1];
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

### src/rational_accumulator_alu.sv
// ============================================================================
// rational_accumulator_alu
// Fraction accumulator: load/add/sub/mul/div, reduced by a Euclidean GCD.
// ============================================================================
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid / in_ready  | in_func, in_op_num, in_op_den
//  out     | output    | out_valid / out_ready| out_res_num, out_res_den,
//          |           |                      | out_status
//
//  One word in flight; in_ready is high only in IDLE. Unused func codes go from IDLE to FIN.
//  Setup and products: load goes straight to the zero check, mul and div form two products,
//  add and sub three products and a signed sum; then one division per Euclid remainder step
//  and two quotients on the one bit-serial divider, then range check and hand-off.
//  Reset (synchronous, active low) clears the sequencer and sets the fraction to 0/1.
//  A stalled result holds FIN; a word waiting in the output register does not block input.
// ============================================================================
`default_nettype none

module rational_accumulator_alu #(
  parameter int WIDTH = rac_pkg::RAC_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [2:0]                      in_func,
  input  wire logic signed [rac_pkg::OP_W-1:0] in_op_num,
  input  wire logic signed [rac_pkg::OP_W-1:0] in_op_den,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [rac_pkg::OP_W-1:0]      out_res_num,
  output logic signed [rac_pkg::OP_W-1:0]      out_res_den,
  output logic [1:0]                           out_status
);
  import rac_pkg::*;

  // Bound on the magnitude of a reduced value: 2^(WIDTH-1).
  localparam logic [DIV_W-1:0] LIM = DIV_W'(1) << (WIDTH - 1);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_MUL_A = 12'b0000_0000_0010,  // first product into the numerator
    ST_MUL_B = 12'b0000_0000_0100,  // second product
    ST_MUL_C = 12'b0000_0000_1000,  // denominator product for add/sub
    ST_SUM   = 12'b0000_0001_0000,  // signed sum of the cross products
    ST_ZCHK  = 12'b0000_0010_0000,  // zero denominator check, seed Euclid
    ST_GCD   = 12'b0000_0100_0000,  // test remainder, launch next division
    ST_REM   = 12'b0000_1000_0000,  // wait for remainder
    ST_QN    = 12'b0001_0000_0000,  // wait for numerator quotient
    ST_QD    = 12'b0010_0000_0000,  // wait for denominator quotient
    ST_CHK   = 12'b0100_0000_0000,  // range check of the reduced pair
    ST_FIN   = 12'b1000_0000_0000   // hand the word to the output side
  } state_t;

  state_t  state_r, state_nxt;
  logic [2:0] func_r, func_nxt;
  sm32_t   an_r, an_nxt, ad_r, ad_nxt;
  sm32_t   on_r, on_nxt, od_r, od_nxt;
  sm64_t   pn_r, pn_nxt, pd_r, pd_nxt, t_r, t_nxt;
  sm64_t   n_r, n_nxt, d_r, d_nxt;
  status_t status_r, status_nxt;
  logic    upd_r, upd_nxt;
  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  logic signed [WIDTH-1:0] acc_num_r, acc_num_nxt;
  logic signed [WIDTH-1:0] acc_den_r, acc_den_nxt;

  // Shared multiplier.
  logic [OP_W-1:0]  mul_a, mul_b;
  logic             mul_neg;
  logic [DIV_W-1:0] prod;

  // Adder for the cross-product sum.
  logic [DIV_W:0]   sdiff;

  // Two's complement of the reduced pair.
  logic [DIV_W-1:0] rn_tc, rd_tc;
  logic             fits_n, fits_d;
  logic             fin_fire;
  logic             arith;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rac_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign prod   = DIV_W'(mul_a) * DIV_W'(mul_b);
  assign sdiff  = {1'b0, pn_r.mag} - {1'b0, t_r.mag};
  assign rn_tc  = pn_r.neg ? (~pn_r.mag + DIV_W'(1)) : pn_r.mag;
  assign rd_tc  = pd_r.neg ? (~pd_r.mag + DIV_W'(1)) : pd_r.mag;
  assign fits_n = pn_r.neg ? (pn_r.mag <= LIM) : (pn_r.mag < LIM);
  assign fits_d = pd_r.neg ? (pd_r.mag <= LIM) : (pd_r.mag < LIM);
  assign fin_fire = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  assign arith  = (in_func inside {FN_ADD, FN_SUB, FN_MUL, FN_DIV});

  // Pick the multiplier operands for each product step.
  always_comb begin
    mul_a   = an_r.mag;
    mul_b   = od_r.mag;
    mul_neg = an_r.neg ^ od_r.neg;
    case (state_r)
      ST_MUL_A: begin
        mul_a = an_r.mag;
        if (func_r == FN_MUL) begin
          mul_b   = on_r.mag;
          mul_neg = an_r.neg ^ on_r.neg;
        end else begin
          mul_b   = od_r.mag;
          mul_neg = an_r.neg ^ od_r.neg;
        end
      end
      ST_MUL_B: begin
        if (func_r == FN_ADD || func_r == FN_SUB) begin
          mul_a   = on_r.mag;
          mul_b   = ad_r.mag;
          mul_neg = on_r.neg ^ ad_r.neg;
        end else if (func_r == FN_DIV) begin
          mul_a   = ad_r.mag;
          mul_b   = on_r.mag;
          mul_neg = ad_r.neg ^ on_r.neg;
        end else begin
          mul_a   = ad_r.mag;
          mul_b   = od_r.mag;
          mul_neg = ad_r.neg ^ od_r.neg;
        end
      end
      ST_MUL_C: begin
        mul_a   = ad_r.mag;
        mul_b   = od_r.mag;
        mul_neg = ad_r.neg ^ od_r.neg;
      end
      default: begin
        mul_a   = an_r.mag;
        mul_b   = od_r.mag;
        mul_neg = an_r.neg ^ od_r.neg;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    an_nxt         = an_r;
    ad_nxt         = ad_r;
    on_nxt         = on_r;
    od_nxt         = od_r;
    pn_nxt         = pn_r;
    pd_nxt         = pd_r;
    t_nxt          = t_r;
    n_nxt          = n_r;
    d_nxt          = d_r;
    status_nxt     = status_r;
    upd_nxt        = upd_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    acc_num_nxt    = acc_num_r;
    acc_den_nxt    = acc_den_r;
    div_req        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func;
          an_nxt   = to_sm32(OP_W'(acc_num_r));
          ad_nxt   = to_sm32(OP_W'(acc_den_r));
          on_nxt   = to_sm32(in_op_num);
          od_nxt   = to_sm32(in_op_den);
          if (in_func == FN_SUB) begin
            on_nxt.neg = ~on_nxt.neg;
          end
          if (in_func == FN_LOAD) begin
            pn_nxt    = {on_nxt.neg, DIV_W'(on_nxt.mag)};
            pd_nxt    = {od_nxt.neg, DIV_W'(od_nxt.mag)};
            state_nxt = ST_ZCHK;
          end else if (arith) begin
            state_nxt = ST_MUL_A;
          end else begin
            // Unused code: keep the fraction, report ok.
            status_nxt = STAT_OK;
            upd_nxt    = 1'b0;
            state_nxt  = ST_FIN;
          end
        end
      end
      ST_MUL_A: begin
        pn_nxt    = {mul_neg, prod};
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        if (func_r == FN_ADD || func_r == FN_SUB) begin
          t_nxt     = {mul_neg, prod};
          state_nxt = ST_MUL_C;
        end else begin
          pd_nxt    = {mul_neg, prod};
          state_nxt = ST_ZCHK;
        end
      end
      ST_MUL_C: begin
        pd_nxt    = {mul_neg, prod};
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (pn_r.neg == t_r.neg) begin
          pn_nxt.mag = pn_r.mag + t_r.mag;
        end else if (!sdiff[DIV_W]) begin
          pn_nxt.mag = sdiff[DIV_W-1:0];
        end else begin
          pn_nxt.neg = t_r.neg;
          pn_nxt.mag = ~sdiff[DIV_W-1:0] + DIV_W'(1);
        end
        state_nxt = ST_ZCHK;
      end
      ST_ZCHK: begin
        if (pd_r.mag == '0) begin
          status_nxt = STAT_ZERO_DEN;
          upd_nxt    = 1'b0;
          state_nxt  = ST_FIN;
        end else begin
          n_nxt     = pn_r;
          d_nxt     = pd_r;
          state_nxt = ST_GCD;
        end
      end
      ST_GCD: begin
        div_req.start = 1'b1;
        if (n_r.mag == '0) begin
          // d holds the GCD; divide the numerator by it.
          div_req.dividend = pn_r.mag;
          div_req.divisor  = d_r.mag;
          state_nxt        = ST_QN;
        end else begin
          div_req.dividend = d_r.mag;
          div_req.divisor  = n_r.mag;
          state_nxt        = ST_REM;
        end
      end
      ST_REM: begin
        if (div_rsp.done) begin
          // Truncating remainder takes the dividend's sign.
          d_nxt     = n_r;
          n_nxt     = {d_r.neg, div_rsp.rem};
          state_nxt = ST_GCD;
        end
      end
      ST_QN: begin
        if (div_rsp.done) begin
          pn_nxt.mag = div_rsp.quot;
          pn_nxt.neg = (div_rsp.quot != '0) && (pn_r.neg != d_r.neg);
          div_req.start    = 1'b1;
          div_req.dividend = pd_r.mag;
          div_req.divisor  = d_r.mag;
          state_nxt        = ST_QD;
        end
      end
      ST_QD: begin
        if (div_rsp.done) begin
          pd_nxt.mag = div_rsp.quot;
          pd_nxt.neg = (div_rsp.quot != '0) && (pd_r.neg != d_r.neg);
          state_nxt  = ST_CHK;
        end
      end
      ST_CHK: begin
        if (fits_n && fits_d) begin
          status_nxt = STAT_OK;
          upd_nxt    = 1'b1;
        end else begin
          status_nxt = STAT_OVERFLOW;
          upd_nxt    = 1'b0;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // The fraction registers double as the output word.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          if (upd_r) begin
            acc_num_nxt = rn_tc[WIDTH-1:0];
            acc_den_nxt = rd_tc[WIDTH-1:0];
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      acc_num_r   <= '0;
      acc_den_r   <= WIDTH'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      acc_num_r   <= acc_num_nxt;
      acc_den_r   <= acc_den_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    an_r         <= an_nxt;
    ad_r         <= ad_nxt;
    on_r         <= on_nxt;
    od_r         <= od_nxt;
    pn_r         <= pn_nxt;
    pd_r         <= pd_nxt;
    t_r          <= t_nxt;
    n_r          <= n_nxt;
    d_r          <= d_nxt;
    status_r     <= status_nxt;
    upd_r        <= upd_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_res_num = OP_W'(acc_num_r);
  assign out_res_den = OP_W'(acc_den_r);
  assign out_status  = out_status_r;

  // Ready drops once a word is accepted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word but stayed ready");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_ZERO_DEN ||
                   out_status == STAT_OVERFLOW))
    else $error("illegal status code");

  a_keep_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    fin_fire && (status_r != STAT_OK) |=> $stable(acc_num_r) && $stable(acc_den_r))
    else $error("fraction changed on a faulted word");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    acc_den_r != '0)
    else $error("held denominator is zero");

endmodule

`default_nettype wire
